// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hiff_pkg.sv -----
`default_nettype none

package hiff_pkg;

    localparam int HIFF_MAX_LEVELS = 16;
    localparam int CFG_W           = 5;
    localparam int FIT_W           = 21;
    localparam int CLASS_W         = 2;
    localparam int SYM_W           = 2;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd6;

    // Symbol codes carried between cells and held as pending left halves
    localparam logic [SYM_W-1:0] SYM_ZERO  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE   = 2'd1;
    localparam logic [SYM_W-1:0] SYM_EMPTY = 2'd2;
    localparam logic [SYM_W-1:0] SYM_NULL  = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_ZEROS = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ONES  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MIXED = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic [FIT_W-1:0] score;
    } t_carry;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [FIT_W-1:0]   fitness;
    } t_result;

    function automatic logic [CFG_W-1:0] clamp_levels(input logic [CFG_W-1:0] raw,
                                                      input logic [CFG_W-1:0] max_lv);
        logic [CFG_W-1:0] lv;
        lv = raw;
        if (lv < CFG_W'(1)) begin
            lv = CFG_W'(1);
        end
        if (lv > max_lv) begin
            lv = max_lv;
        end
        return lv;
    endfunction

    function automatic logic [CLASS_W-1:0] sym_to_class(input logic [SYM_W-1:0] sym);
        logic [CLASS_W-1:0] cls;
        unique case (sym)
            SYM_ZERO: cls = CLASS_ZEROS;
            SYM_ONE:  cls = CLASS_ONES;
            default:  cls = CLASS_MIXED;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- design/hiff_cell.sv -----
`default_nettype none

module hiff_cell #(
    parameter int LEVEL = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clear,
    input  wire logic            i_adv,
    input  wire hiff_pkg::t_carry i_carry,
    output hiff_pkg::t_carry     o_carry
);
    import hiff_pkg::*;

    localparam logic [FIT_W-1:0] Bonus = FIT_W'(2) << LEVEL;

    logic [SYM_W-1:0] r_pend,        n_pend;
    logic [FIT_W-1:0] r_pend_score,  n_pend_score;
    logic             r_out_valid,   n_out_valid;
    logic [SYM_W-1:0] r_out_sym,     n_out_sym;
    logic [FIT_W-1:0] r_out_score,   n_out_score;
    logic [FIT_W-1:0] w_pair_sum;

    assign w_pair_sum = r_pend_score + i_carry.score;

    always_comb begin
        n_pend       = r_pend;
        n_pend_score = r_pend_score;
        n_out_valid  = 1'b0;
        n_out_sym    = r_out_sym;
        n_out_score  = r_out_score;
        if (i_carry.valid) begin
            if (r_pend == SYM_EMPTY) begin
                // hold the left half until its partner arrives
                n_pend       = i_carry.sym;
                n_pend_score = i_carry.score;
            end else begin
                n_pend      = SYM_EMPTY;
                n_out_valid = 1'b1;
                if (r_pend == i_carry.sym && i_carry.sym != SYM_NULL) begin
                    n_out_sym   = i_carry.sym;
                    n_out_score = w_pair_sum + Bonus;
                end else begin
                    n_out_sym   = SYM_NULL;
                    n_out_score = w_pair_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pend      <= SYM_EMPTY;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pend_score <= n_pend_score;
            r_out_sym    <= n_out_sym;
            r_out_score  <= n_out_score;
        end
    end

    assign o_carry.valid = r_out_valid;
    assign o_carry.sym   = r_out_sym;
    assign o_carry.score = r_out_score;

endmodule

`default_nettype wire

// ----- design/hiff_out_buf.sv -----
`default_nettype none

module hiff_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire hiff_pkg::t_result i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output hiff_pkg::t_result     o_data
);
    import hiff_pkg::*;

    `include "assert_macros.svh"

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    w_free;

    // output slot free this cycle: empty or its beat is being taken
    assign w_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = i_data;
                n_skid_valid = i_valid;
            end else begin
                n_out       = i_data;
                n_out_valid = i_valid;
            end
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid, "skid beat without output beat")
    `ASSERT_IMPL(a_class_code, r_out_valid,
                 (r_out.cls == CLASS_ZEROS || r_out.cls == CLASS_ONES ||
                  r_out.cls == CLASS_MIXED), "bad optimum class code")

endmodule

`default_nettype wire

// ----- design/hiff_fitness_evaluator_core.sv -----
`default_nettype none

// Channel   Direction  Beat contents (low bit first)
// s_axis    in         tdata[0] gene, tdata[7:1] zero
// m_axis    out        tdata[20:0] fitness, tdata[22:21] optimum class, tdata[23] zero
// cfg       in         data[4:0] string levels L, taken every cycle
//
// One gene is taken per cycle while the row advances; the row of level cells merges one
// level per cycle, and a result goes from the string's top cell to the output register.
// Reset (synchronous, active low) empties every cell and sets L to 6.
// A configuration write discards the string in progress.
// A two-slot output buffer holds results under back-pressure; genes are refused
// only while its second slot is occupied, and the whole cell row freezes then.

module hiff_fitness_evaluator_core #(
    parameter int MAX_LEVELS = hiff_pkg::HIFF_MAX_LEVELS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [7:0]                 i_s_axis_tdata,   // [0] gene
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,   // [20:0] fitness, [22:21] class
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [hiff_pkg::CFG_W-1:0] i_cfg_data
);
    import hiff_pkg::*;

    `include "assert_macros.svh"

    logic [CFG_W-1:0] r_eff_levels;
    logic             w_adv;
    logic             w_cfg_wr;
    t_carry           w_cell_in  [MAX_LEVELS];
    t_carry           w_cell_out [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] w_top_sel;
    logic [MAX_LEVELS-1:0] w_carry_valid;
    logic             w_res_valid;
    logic [SYM_W-1:0] w_res_sym;
    logic [FIT_W-1:0] w_res_score;
    t_result          w_res;
    t_result          w_out;
    logic             w_buf_ready;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_levels <= clamp_levels(LEVELS_RESET, CFG_W'(MAX_LEVELS));
        end else if (w_cfg_wr) begin
            r_eff_levels <= clamp_levels(i_cfg_data, CFG_W'(MAX_LEVELS));
        end
    end

    assign w_adv           = w_buf_ready;
    assign o_s_axis_tready = w_adv;

    assign w_cell_in[0].valid = i_s_axis_tvalid && w_adv;
    assign w_cell_in[0].sym   = {1'b0, i_s_axis_tdata[0]};
    assign w_cell_in[0].score = '0;

    for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_cell
        if (l > 0) begin : g_link
            // pass the carry up only while this level is inside the string
            assign w_cell_in[l].valid = w_cell_out[l-1].valid &&
                                        (CFG_W'(l) < r_eff_levels);
            assign w_cell_in[l].sym   = w_cell_out[l-1].sym;
            assign w_cell_in[l].score = w_cell_out[l-1].score;
        end

        hiff_cell #(
            .LEVEL (l)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_cfg_wr),
            .i_adv   (w_adv),
            .i_carry (w_cell_in[l]),
            .o_carry (w_cell_out[l])
        );

        assign w_top_sel[l]     = (r_eff_levels == CFG_W'(l + 1));
        assign w_carry_valid[l] = w_cell_out[l].valid;
    end

    // pick the carry leaving the top level of the current string length
    always_comb begin
        w_res_valid = 1'b0;
        w_res_sym   = '0;
        w_res_score = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            w_res_valid = w_res_valid | (w_cell_out[l].valid & w_top_sel[l]);
            w_res_sym   = w_res_sym   | (w_cell_out[l].sym & {SYM_W{w_top_sel[l]}});
            w_res_score = w_res_score | (w_cell_out[l].score & {FIT_W{w_top_sel[l]}});
        end
    end

    assign w_res.fitness = (FIT_W'(1) << r_eff_levels) + w_res_score;
    assign w_res.cls     = sym_to_class(w_res_sym);

    hiff_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid && w_adv),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    assign o_m_axis_tdata = {1'b0, w_out.cls, w_out.fitness};

    `ASSERT_NEXT(a_cfg_clears_row, w_cfg_wr, (w_carry_valid == '0),
                 "carry left in cell row after length write")

endmodule

`default_nettype wire

// ----- bench/hiff_fitness_evaluator_core_tb.sv -----
`timescale 1ns / 100ps

module hiff_fitness_evaluator_core_tb;
    import hiff_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 5000;
    localparam int QUIET_CYCLES  = HIFF_MAX_LEVELS + 4;
    localparam int RANDOM_GENES  = 1700;
    localparam int MAX_PRINTED   = 100;

    typedef struct {
        logic [FIT_W-1:0]   fitness;
        logic [CLASS_W-1:0] cls;
    } t_score;

    typedef enum {ROW_CFG, ROW_GENES} t_row_kind;
    typedef enum {FILL_NOISE, FILL_BLOCKS, FILL_ONES, FILL_ZEROS, FILL_FLIP} t_fill;

    // arg: register value for ROW_CFG, gene count for ROW_GENES (first gene in bit 0)
    typedef struct {
        t_row_kind          kind;
        int                 arg;
        logic [63:0]        bits;
        bit                 typed;
        logic [FIT_W-1:0]   fit;
        logic [CLASS_W-1:0] cls;
    } t_row;

    t_row plan [0:14] = '{
        '{ROW_GENES, 64, 64'h0,     1'b1, 21'd448, CLASS_ZEROS},
        '{ROW_GENES, 3,  64'b101,   1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_CFG,   0,  64'h0,     1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_GENES, 2,  64'b00,    1'b1, 21'd4,   CLASS_ZEROS},
        '{ROW_GENES, 2,  64'b11,    1'b1, 21'd4,   CLASS_ONES},
        '{ROW_GENES, 2,  64'b01,    1'b1, 21'd2,   CLASS_MIXED},
        '{ROW_GENES, 2,  64'b10,    1'b1, 21'd2,   CLASS_MIXED},
        '{ROW_CFG,   2,  64'h0,     1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_GENES, 4,  64'b1111,  1'b1, 21'd12,  CLASS_ONES},
        '{ROW_GENES, 4,  64'b1100,  1'b1, 21'd8,   CLASS_MIXED},
        '{ROW_GENES, 4,  64'b0110,  1'b1, 21'd4,   CLASS_MIXED},
        '{ROW_GENES, 4,  64'b0111,  1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_GENES, 1,  64'b1,     1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_CFG,   1,  64'h0,     1'b0, 21'd0,   CLASS_ZEROS},
        '{ROW_GENES, 2,  64'b10,    1'b0, 21'd0,   CLASS_ZEROS}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic             s_valid = 1'b0;
    logic [7:0]       s_data  = 8'd0;
    logic             m_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    // Scoring state mirrored on the bench side
    logic [SYM_W-1:0] pending [HIFF_MAX_LEVELS];
    logic [CFG_W-1:0] levels_reg;
    logic [FIT_W-1:0] bonus;
    t_score           score_q [$];
    t_score           typed_want;
    bit               typed_armed = 1'b0;

    int mismatches  = 0;
    int cycles      = 0;
    int burst_left  = 0;
    int burst_max   = 8;
    int gap_max     = 4;

    hiff_fitness_evaluator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),        // [0] gene, [7:1] zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // [20:0] fitness, [22:21] class, [23] zero
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int span_of(input logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > HIFF_MAX_LEVELS) return HIFF_MAX_LEVELS;
        return int'(v);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic wipe_string();
        for (int l = 0; l < HIFF_MAX_LEVELS; l++) pending[l] = SYM_EMPTY;
        bonus = '0;
    endtask

    // Merge one gene up the level chain; a result falls out at the top level.
    task automatic fold_gene(input logic g);
        int               lv;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] left;
        t_score           want;
        lv  = span_of(levels_reg);
        sym = g ? SYM_ONE : SYM_ZERO;
        for (int l = 0; l < lv; l++) begin
            left = pending[l];
            if (left == SYM_EMPTY) begin
                pending[l] = sym;
                return;
            end
            pending[l] = SYM_EMPTY;
            if (left == sym && sym != SYM_NULL) begin
                bonus = bonus + (FIT_W'(2) << l);
            end else begin
                sym = SYM_NULL;
            end
        end
        want.fitness = (FIT_W'(1) << lv) + bonus;
        want.cls     = (sym == SYM_ZERO) ? CLASS_ZEROS :
                       (sym == SYM_ONE)  ? CLASS_ONES  : CLASS_MIXED;
        if (typed_armed) begin
            want        = typed_want;
            typed_armed = 1'b0;
        end
        score_q.push_back(want);
        wipe_string();
    endtask

    task automatic check_score(input logic [23:0] beat);
        t_score want;
        if (score_q.size() == 0) begin
            flag_mismatch("result with nothing expected", int'(beat[FIT_W-1:0]), 0);
            return;
        end
        want = score_q.pop_front();
        if (beat[FIT_W-1:0] !== want.fitness)
            flag_mismatch("fitness", int'(beat[FIT_W-1:0]), int'(want.fitness));
        if (beat[FIT_W +: CLASS_W] !== want.cls)
            flag_mismatch("optimum class", int'(beat[FIT_W +: CLASS_W]), int'(want.cls));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            levels_reg = LEVELS_RESET;
            wipe_string();
        end else begin
            if (o_m_axis_tvalid && m_ready) check_score(o_m_axis_tdata);
            if (cfg_valid && o_cfg_ready) begin
                levels_reg = cfg_data;
                wipe_string();
            end
            if (s_valid && o_s_axis_tready) fold_gene(s_data[0]);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("hiff_fitness_evaluator_core_tb: FAIL");
            $finish;
        end
    end

    // Receiver: alternate ready runs and stall runs, now and then a long open stretch
    bit rdy_state = 1'b0;
    int rdy_left  = 0;
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_state = ~rdy_state;
            if (rdy_state)
                rdy_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            else
                rdy_left = $urandom_range(1, 15);
        end
        m_ready <= rdy_state;
        rdy_left--;
    end

    task automatic push_gene(input logic g);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_valid <= 1'b0;
                s_data  <= {7'd0, 1'($urandom_range(0, 1))};
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, g};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Hold the sender, wait for every outstanding score, then let the cell row empty.
    task automatic drain();
        int waited;
        s_valid    <= 1'b0;
        burst_left = 0;
        waited     = 0;
        while (score_q.size() != 0 && waited < DRAIN_CYCLES) begin
            @(negedge i_clk);
            waited++;
        end
        while (score_q.size() != 0) begin
            flag_mismatch("result never arrived", 0, int'(score_q[0].fitness));
            score_q.delete(0);
        end
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_string(input int n, input t_fill fill);
        int   blk;
        int   flip_at;
        logic cur;
        logic base;
        blk     = 1 << $urandom_range(0, $clog2(n));
        flip_at = $urandom_range(0, n - 1);
        base    = 1'($urandom_range(0, 1));
        cur     = base;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_NOISE:  cur = 1'($urandom_range(0, 1));
                FILL_BLOCKS: if (i % blk == 0) cur = 1'($urandom_range(0, 1));
                FILL_ONES:   cur = 1'b1;
                FILL_ZEROS:  cur = 1'b0;
                default:     cur = base ^ (i == flip_at);
            endcase
            push_gene(cur);
        end
    endtask

    initial begin
        t_row        r;
        int          sent;
        int          pick;
        int          span;
        int          len;
        int          part;
        logic [CFG_W-1:0] v;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            r = plan[k];
            if (r.kind == ROW_CFG) begin
                write_levels(CFG_W'(r.arg));
            end else begin
                if (r.typed) begin
                    typed_want.fitness = r.fit;
                    typed_want.cls     = r.cls;
                    typed_armed        = 1'b1;
                end
                for (int i = 0; i < r.arg; i++) push_gene(r.bits[i]);
            end
        end

        sent = 0;
        while (sent < RANDOM_GENES) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      v = '0;
            else if (pick == 9) v = CFG_W'($urandom_range(7, 8));
            else                v = CFG_W'($urandom_range(1, 6));
            span = span_of(v);
            len  = 1 << span;
            write_levels(v);
            burst_max = $urandom_range(1, 32);
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat ($urandom_range(1, ((128 >> span) > 1) ? (128 >> span) : 1)) begin
                play_string(len, t_fill'($urandom_range(0, 4)));
                sent += len;
            end
            // leave a partial string for the next register write to discard
            if ($urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, len - 1);
                play_string(part, FILL_NOISE);
                sent += part;
            end
        end

        // Length above the top level: clamp to the widest string, no result may appear
        write_levels('1);
        play_string(60, FILL_NOISE);

        drain();
        if (mismatches == 0)
            $display("hiff_fitness_evaluator_core_tb: PASS");
        else
            $display("hiff_fitness_evaluator_core_tb: FAIL");
        $finish;
    end

endmodule
